// ===== rtl/fptm_pkg.sv =====
// shared constants, types and helpers of the four-level page table mapper
`timescale 1ns / 1ps
package fptm_pkg;
	localparam int TABLE_PAGES = 64;
	localparam int ENTRIES     = 512;
	localparam int IDX_W       = $clog2(ENTRIES);
	localparam int PAGE_W      = $clog2(TABLE_PAGES);
	localparam int ADDR_W      = PAGE_W + IDX_W;
	localparam int DEPTH       = TABLE_PAGES * ENTRIES;
	localparam int NF_W        = $clog2(TABLE_PAGES + 1);
	localparam int FRAME_W     = 40;
	localparam int VP_W        = 36;
	localparam int ENTRY_W     = 64;
	localparam int STATUS_W    = 3;
	localparam int LVL_W       = 2;

	localparam logic [2:0] FLAGS_PWU = 3'b111;
	localparam logic       REQ_MAP   = 1'b0;
	localparam logic       REQ_UNMAP = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_MAPPED     = 3'd1,
		ST_NOT_MAPPED = 3'd2,
		ST_EXHAUSTED  = 3'd3,
		ST_OUTSIDE    = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_READ,
		S_EVAL,
		S_PGCLR,
		S_LINK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic               we;
		logic [ADDR_W-1:0]  addr;
		logic [ENTRY_W-1:0] wdata;
	} mem_req_t;

	typedef struct packed {
		logic            init_busy;
		logic [NF_W-1:0] next_free;
	} ctrl_stat_t;

	function automatic logic [IDX_W-1:0] level_index(input logic [VP_W-1:0] vp,
			input logic [LVL_W-1:0] lvl);
		logic [IDX_W-1:0] idx;
		case (lvl)
			2'd0:    idx = vp[35:27];
			2'd1:    idx = vp[26:18];
			2'd2:    idx = vp[17:9];
			default: idx = vp[8:0];
		endcase
		return idx;
	endfunction
endpackage

// ===== rtl/fptm_ifs.sv =====
// channel interfaces of the page table mapper
`timescale 1ns / 1ps
interface fptm_req_if;
	logic                         valid;
	logic                         ready;
	logic                         req_type;
	logic [fptm_pkg::VP_W-1:0]    virt_page;
	logic [fptm_pkg::FRAME_W-1:0] phys_page;
	modport source (output valid, req_type, virt_page, phys_page, input ready);
	modport sink (input valid, req_type, virt_page, phys_page, output ready);
endinterface

interface fptm_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [fptm_pkg::STATUS_W-1:0] status;
	logic [fptm_pkg::FRAME_W-1:0]  old_phys_page;
	modport source (output valid, status, old_phys_page, input ready);
	modport sink (input valid, status, old_phys_page, output ready);
endinterface

interface fptm_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [fptm_pkg::FRAME_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== rtl/fptm_ram.sv =====
// single-port synchronous table store, registered read
`timescale 1ns / 1ps
module fptm_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 64,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else begin
			rdata <= mem[addr];
		end
	end
endmodule

// ===== rtl/fptm_ctrl.sv =====
// walk sequencer: reads, links, clears and writes table entries
`timescale 1ns / 1ps
module fptm_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	fptm_req_if.sink                        req,
	fptm_rsp_if.source                      rsp,
	fptm_cfg_if.sink                        cfg,
	output fptm_pkg::mem_req_t              mem_req,
	input  logic [fptm_pkg::ENTRY_W-1:0]    mem_rdata,
	output fptm_pkg::ctrl_stat_t            stat
);
	fptm_pkg::state_t              state_q, state_d;
	logic [fptm_pkg::ADDR_W-1:0]   clr_q, clr_d;
	logic [fptm_pkg::LVL_W-1:0]    lvl_q, lvl_d;
	logic [fptm_pkg::PAGE_W-1:0]   page_q, page_d;
	logic [fptm_pkg::PAGE_W-1:0]   child_q, child_d;
	logic [fptm_pkg::NF_W-1:0]     nf_q, nf_d;
	logic [fptm_pkg::NF_W-1:0]     stray_q, stray_d;
	logic [fptm_pkg::FRAME_W-1:0]  base_q;
	logic                          type_q, type_d;
	logic [fptm_pkg::VP_W-1:0]     vp_q, vp_d;
	logic [fptm_pkg::FRAME_W-1:0]  pp_q, pp_d;
	fptm_pkg::status_t             res_st_q, res_st_d;
	logic [fptm_pkg::FRAME_W-1:0]  res_old_q, res_old_d;
	logic                          rsp_valid_q, rsp_valid_d;
	fptm_pkg::status_t             rsp_st_q, rsp_st_d;
	logic [fptm_pkg::FRAME_W-1:0]  rsp_old_q, rsp_old_d;

	logic                          present;
	logic [fptm_pkg::FRAME_W-1:0]  frame;
	logic [fptm_pkg::FRAME_W-1:0]  rel;
	logic                          in_store;
	logic [fptm_pkg::NF_W-1:0]     page_ext;
	logic [fptm_pkg::NF_W-1:0]     page_nxt;
	logic [fptm_pkg::FRAME_W-1:0]  child_frame;

	assign present     = mem_rdata[0];
	assign frame       = mem_rdata[51:12];
	assign rel         = frame - base_q;
	assign in_store    = rel < fptm_pkg::FRAME_W'(fptm_pkg::TABLE_PAGES);
	assign page_ext    = fptm_pkg::NF_W'(page_q);
	assign page_nxt    = page_ext + fptm_pkg::NF_W'(1);
	assign child_frame = base_q + fptm_pkg::FRAME_W'(child_q);

	assign cfg.ready          = 1'b1;
	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = rsp_st_q;
	assign rsp.old_phys_page  = rsp_old_q;
	assign stat.init_busy     = (state_q == fptm_pkg::S_INIT);
	assign stat.next_free     = nf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fptm_pkg::S_INIT;
			clr_q       <= '0;
			nf_q        <= fptm_pkg::NF_W'(1);
			stray_q     <= '0;
			base_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			clr_q       <= clr_d;
			nf_q        <= nf_d;
			stray_q     <= stray_d;
			rsp_valid_q <= rsp_valid_d;
			if (cfg.valid) begin
				base_q <= cfg.data;
			end
		end
	end

	always_ff @(posedge clk) begin
		lvl_q     <= lvl_d;
		page_q    <= page_d;
		child_q   <= child_d;
		type_q    <= type_d;
		vp_q      <= vp_d;
		pp_q      <= pp_d;
		res_st_q  <= res_st_d;
		res_old_q <= res_old_d;
		rsp_st_q  <= rsp_st_d;
		rsp_old_q <= rsp_old_d;
	end

	always_comb begin
		state_d     = state_q;
		clr_d       = clr_q;
		lvl_d       = lvl_q;
		page_d      = page_q;
		child_d     = child_q;
		nf_d        = nf_q;
		stray_d     = stray_q;
		type_d      = type_q;
		vp_d        = vp_q;
		pp_d        = pp_q;
		res_st_d    = res_st_q;
		res_old_d   = res_old_q;
		rsp_st_d    = rsp_st_q;
		rsp_old_d   = rsp_old_q;
		rsp_valid_d = rsp_valid_q && !rsp.ready;
		req.ready   = 1'b0;
		mem_req     = '0;
		mem_req.addr = {page_q, fptm_pkg::level_index(vp_q, lvl_q)};
		case (state_q)
			fptm_pkg::S_INIT: begin
				mem_req.we   = 1'b1;
				mem_req.addr = clr_q;
				clr_d        = clr_q + fptm_pkg::ADDR_W'(1);
				if (clr_q == fptm_pkg::ADDR_W'(fptm_pkg::DEPTH - 1)) begin
					clr_d   = '0;
					state_d = fptm_pkg::S_IDLE;
				end
			end
			fptm_pkg::S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					type_d  = req.req_type;
					vp_d    = req.virt_page;
					pp_d    = req.phys_page;
					lvl_d   = '0;
					page_d  = '0;
					state_d = fptm_pkg::S_READ;
				end
			end
			fptm_pkg::S_READ: begin
				state_d = fptm_pkg::S_EVAL;
			end
			fptm_pkg::S_EVAL: begin
				res_old_d = '0;
				state_d   = fptm_pkg::S_DONE;
				if (lvl_q != 2'd3) begin
					if (present) begin
						if (!in_store) begin
							res_st_d = fptm_pkg::ST_OUTSIDE;
						end else begin
							page_d  = rel[fptm_pkg::PAGE_W-1:0];
							lvl_d   = lvl_q + 2'd1;
							state_d = fptm_pkg::S_READ;
						end
					end else if (type_q == fptm_pkg::REQ_UNMAP) begin
						res_st_d = fptm_pkg::ST_NOT_MAPPED;
					end else if (nf_q >= fptm_pkg::NF_W'(fptm_pkg::TABLE_PAGES)) begin
						res_st_d = fptm_pkg::ST_EXHAUSTED;
					end else begin
						child_d = nf_q[fptm_pkg::PAGE_W-1:0];
						nf_d    = nf_q + fptm_pkg::NF_W'(1);
						clr_d   = '0;
						state_d = (nf_q < stray_q) ? fptm_pkg::S_PGCLR : fptm_pkg::S_LINK;
					end
				end else if (type_q == fptm_pkg::REQ_MAP) begin
					if (present) begin
						res_st_d = fptm_pkg::ST_MAPPED;
					end else begin
						res_st_d      = fptm_pkg::ST_OK;
						mem_req.we    = 1'b1;
						mem_req.wdata = {12'd0, pp_q, 9'd0, fptm_pkg::FLAGS_PWU};
					end
				end else begin
					if (!present) begin
						res_st_d = fptm_pkg::ST_NOT_MAPPED;
					end else begin
						res_st_d      = fptm_pkg::ST_OK;
						res_old_d     = frame;
						mem_req.we    = 1'b1;
						mem_req.wdata = {mem_rdata[63:1], 1'b0};
					end
				end
				if (mem_req.we && page_ext >= nf_q && page_nxt > stray_q) begin
					stray_d = page_nxt;
				end
			end
			fptm_pkg::S_PGCLR: begin
				mem_req.we    = 1'b1;
				mem_req.addr  = {child_q, clr_q[fptm_pkg::IDX_W-1:0]};
				mem_req.wdata = '0;
				clr_d         = clr_q + fptm_pkg::ADDR_W'(1);
				if (clr_q[fptm_pkg::IDX_W-1:0] == fptm_pkg::IDX_W'(fptm_pkg::ENTRIES - 1)) begin
					clr_d   = '0;
					state_d = fptm_pkg::S_LINK;
				end
			end
			fptm_pkg::S_LINK: begin
				mem_req.we    = 1'b1;
				mem_req.wdata = {12'd0, child_frame, 9'd0, fptm_pkg::FLAGS_PWU};
				if (page_ext >= nf_q && page_nxt > stray_q) begin
					stray_d = page_nxt;
				end
				page_d  = child_q;
				lvl_d   = lvl_q + 2'd1;
				state_d = fptm_pkg::S_READ;
			end
			fptm_pkg::S_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					rsp_valid_d = 1'b1;
					rsp_st_d    = res_st_q;
					rsp_old_d   = res_old_q;
					state_d     = fptm_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = fptm_pkg::S_IDLE;
			end
		endcase
	end
endmodule

// ===== rtl/four_level_page_table_mapper.sv =====
// Four-level page table mapper. After reset the table store (TABLE_PAGES x 512
// entries) is swept to zero, one entry a cycle, and no request is taken until it
// ends. A request then walks four levels through the single-port store; each level
// costs a read state (S_READ) and an evaluate state (S_EVAL), since every index
// depends on the previous entry, before S_DONE hands over the result. Each new
// table adds a link write (S_LINK), preceded by a clear of its 512 entries
// (S_PGCLR) if that page had been written through a stale pointer. The result
// waits in an output register while the next request runs.
`timescale 1ns / 1ps
module four_level_page_table_mapper (
	input  logic       clk,
	input  logic       arst_n,
	fptm_req_if.sink   req,
	fptm_rsp_if.source rsp,
	fptm_cfg_if.sink   cfg
);
	fptm_pkg::mem_req_t               mem_req;
	logic [fptm_pkg::ENTRY_W-1:0]     mem_rdata;
	fptm_pkg::ctrl_stat_t             stat;

	fptm_ram #(
		.DEPTH (fptm_pkg::DEPTH),
		.WIDTH (fptm_pkg::ENTRY_W),
		.AW    (fptm_pkg::ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.addr  (mem_req.addr),
		.wdata (mem_req.wdata),
		.rdata (mem_rdata)
	);

	fptm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg       (cfg),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata),
		.stat      (stat)
	);

	a_nf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.next_free <= fptm_pkg::NF_W'(fptm_pkg::TABLE_PAGES))
		else $error("allocator past end of store");

	a_no_req_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		stat.init_busy |-> !req.ready)
		else $error("request taken during store sweep");

	a_old_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != fptm_pkg::ST_OK |-> rsp.old_phys_page == '0)
		else $error("old frame returned on failed transaction");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.status <= fptm_pkg::ST_OUTSIDE)
		else $error("status code out of range");
endmodule

// ===== bench/fptm_checker.sv =====
// page table mapper checker: tracks every transaction, predicts results and compares them
`timescale 1ns / 1ps
module fptm_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	input  logic                          req_ready,
	input  logic                          req_type,
	input  logic [fptm_pkg::VP_W-1:0]     virt_page,
	input  logic [fptm_pkg::FRAME_W-1:0]  phys_page,
	input  logic                          rsp_valid,
	input  logic                          rsp_ready,
	input  logic [fptm_pkg::STATUS_W-1:0] status,
	input  logic [fptm_pkg::FRAME_W-1:0]  old_phys_page,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [fptm_pkg::FRAME_W-1:0]  cfg_data,
	output int                            errors,
	output int                            pending
);
	typedef struct packed {
		fptm_pkg::status_t            st;
		logic [fptm_pkg::FRAME_W-1:0] frame;
	} map_result_t;

	map_result_t                  result_q[$];
	logic [fptm_pkg::ENTRY_W-1:0] pt_store [fptm_pkg::DEPTH];
	int unsigned                  next_table;
	logic [fptm_pkg::FRAME_W-1:0] base_frame;

	function automatic bit frame_in_store(input logic [fptm_pkg::ENTRY_W-1:0] e,
			output int unsigned pg);
		logic [fptm_pkg::FRAME_W-1:0] rel;
		rel = e[51:12] - base_frame;
		pg = int'(rel[fptm_pkg::PAGE_W:0]);
		return rel < fptm_pkg::TABLE_PAGES;
	endfunction

	function automatic map_result_t walk_tables(input logic rt,
			input logic [fptm_pkg::VP_W-1:0] vp, input logic [fptm_pkg::FRAME_W-1:0] pp);
		int unsigned                  pg;
		int unsigned                  slot;
		int unsigned                  child;
		logic [fptm_pkg::ENTRY_W-1:0] e;
		logic [fptm_pkg::FRAME_W-1:0] tframe;
		map_result_t                  r;
		r.st = fptm_pkg::ST_OK;
		r.frame = '0;
		pg = 0;
		for (int lvl = 0; lvl < 3; lvl++) begin
			slot = pg * fptm_pkg::ENTRIES + vp[35-9*lvl -: 9];
			e = pt_store[slot];
			if (e[0]) begin
				if (!frame_in_store(e, pg)) begin
					r.st = fptm_pkg::ST_OUTSIDE;
					return r;
				end
			end else if (rt == fptm_pkg::REQ_UNMAP) begin
				r.st = fptm_pkg::ST_NOT_MAPPED;
				return r;
			end else if (next_table >= fptm_pkg::TABLE_PAGES) begin
				r.st = fptm_pkg::ST_EXHAUSTED;
				return r;
			end else begin
				child = next_table++;
				for (int i = 0; i < fptm_pkg::ENTRIES; i++)
					pt_store[child * fptm_pkg::ENTRIES + i] = '0;
				tframe = base_frame + fptm_pkg::FRAME_W'(child);
				pt_store[slot] = {12'b0, tframe, 9'b0, fptm_pkg::FLAGS_PWU};
				pg = child;
			end
		end
		slot = pg * fptm_pkg::ENTRIES + vp[8:0];
		e = pt_store[slot];
		if (rt == fptm_pkg::REQ_MAP) begin
			if (e[0])
				r.st = fptm_pkg::ST_MAPPED;
			else
				pt_store[slot] = {12'b0, pp, 9'b0, fptm_pkg::FLAGS_PWU};
		end else if (!e[0]) begin
			r.st = fptm_pkg::ST_NOT_MAPPED;
		end else begin
			pt_store[slot][0] = 1'b0;
			r.frame = e[51:12];
		end
		return r;
	endfunction

	initial begin
		errors = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		map_result_t exp_r;
		if (!arst_n) begin
			result_q.delete();
			for (int i = 0; i < fptm_pkg::DEPTH; i++)
				pt_store[i] = '0;
			next_table = 1;
			base_frame = '0;
		end else begin
			if (cfg_valid && cfg_ready)
				base_frame = cfg_data;
			if (req_valid && req_ready)
				result_q.push_back(walk_tables(req_type, virt_page, phys_page));
			if (rsp_valid && rsp_ready) begin
				if (result_q.size() == 0) begin
					$error("unexpected transaction: status %0d old_phys_page 0x%0h",
						status, old_phys_page);
					errors++;
				end else begin
					exp_r = result_q.pop_front();
					if (status !== exp_r.st) begin
						$error("status: expected %0d actual %0d", exp_r.st, status);
						errors++;
					end
					if (old_phys_page !== exp_r.frame) begin
						$error("old_phys_page: expected 0x%0h actual 0x%0h",
							exp_r.frame, old_phys_page);
						errors++;
					end
				end
			end
		end
		pending = result_q.size();
	end
endmodule

// ===== bench/tb_four_level_page_table_mapper.sv =====
// testbench top of the page table mapper: stimulus, watchdog and verdict
`timescale 1ns / 1ps
module tb_four_level_page_table_mapper;
	localparam int WATCHDOG_LIMIT = 200000;
	localparam int PHASE_ITEMS    = 420;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   idle_cycles;
	bit   no_gaps;
	int   rsp_stall;
	logic [fptm_pkg::IDX_W-1:0] idx_pool [4][4];

	fptm_req_if req_if ();
	fptm_rsp_if rsp_if ();
	fptm_cfg_if cfg_if ();

	four_level_page_table_mapper dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if.sink),
		.rsp    (rsp_if.source),
		.cfg    (cfg_if.sink)
	);

	fptm_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_if.valid),
		.req_ready     (req_if.ready),
		.req_type      (req_if.req_type),
		.virt_page     (req_if.virt_page),
		.phys_page     (req_if.phys_page),
		.rsp_valid     (rsp_if.valid),
		.rsp_ready     (rsp_if.ready),
		.status        (rsp_if.status),
		.old_phys_page (rsp_if.old_phys_page),
		.cfg_valid     (cfg_if.valid),
		.cfg_ready     (cfg_if.ready),
		.cfg_data      (cfg_if.data),
		.errors        (errors),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// mostly reuse a few index values per level so walks share tables
	function automatic logic [fptm_pkg::VP_W-1:0] pick_vp();
		logic [fptm_pkg::VP_W-1:0] vp;
		vp = fptm_pkg::VP_W'({$urandom, $urandom});
		for (int lvl = 0; lvl < 4; lvl++)
			if ($urandom_range(0, 99) < 88)
				vp[35-9*lvl -: 9] = idx_pool[lvl][$urandom_range(0, 3)];
		return vp;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			rsp_stall <= 0;
		end else if (rsp_stall > 0) begin
			rsp_if.ready <= 1'b0;
			rsp_stall <= rsp_stall - 1;
		end else begin
			rsp_if.ready <= 1'b1;
			rsp_stall <= gap_len();
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
				|| (cfg_if.valid && cfg_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_four_level_page_table_mapper: FAIL");
			$finish;
		end
	end

	task automatic send_req(input logic rt, input logic [fptm_pkg::VP_W-1:0] vp,
			input logic [fptm_pkg::FRAME_W-1:0] pp);
		int gap;
		req_if.valid <= 1'b1;
		req_if.req_type <= rt;
		req_if.virt_page <= vp;
		req_if.phys_page <= pp;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		gap = gap_len();
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_base(input logic [fptm_pkg::FRAME_W-1:0] base);
		req_if.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (40) @(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.data <= base;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	initial begin
		logic [fptm_pkg::VP_W-1:0] vp;
		logic [fptm_pkg::FRAME_W-1:0] bases [4];
		req_if.valid = 1'b0;
		req_if.req_type = fptm_pkg::REQ_MAP;
		req_if.virt_page = '0;
		req_if.phys_page = '0;
		cfg_if.valid = 1'b0;
		cfg_if.data = '0;
		rsp_if.ready = 1'b0;
		idle_cycles = 0;
		no_gaps = 1'b0;
		for (int lvl = 0; lvl < 4; lvl++) begin
			idx_pool[lvl][0] = '0;
			idx_pool[lvl][1] = '1;
			idx_pool[lvl][2] = fptm_pkg::IDX_W'($urandom);
			idx_pool[lvl][3] = fptm_pkg::IDX_W'($urandom);
		end
		bases[0] = '0;
		bases[1] = '1;
		bases[2] = fptm_pkg::FRAME_W'({$urandom, $urandom});
		bases[3] = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_base(bases[0]);

		// empty store, full-range fields, remap, double unmap
		send_req(fptm_pkg::REQ_UNMAP, '1, '0);
		send_req(fptm_pkg::REQ_MAP, '0, '0);
		send_req(fptm_pkg::REQ_MAP, '1, '1);
		send_req(fptm_pkg::REQ_MAP, '0, '1);
		send_req(fptm_pkg::REQ_UNMAP, '0, '1);
		send_req(fptm_pkg::REQ_UNMAP, '0, '0);
		send_req(fptm_pkg::REQ_UNMAP, '1, '0);
		send_req(fptm_pkg::REQ_MAP, 36'h0_0000_0001, 40'h55_5555_5555);
		send_req(fptm_pkg::REQ_MAP, 36'h0_0000_0200, 40'hAA_AAAA_AAAA);
		send_req(fptm_pkg::REQ_UNMAP, 36'h0_0000_0002, '0);
		send_req(fptm_pkg::REQ_UNMAP, 36'h0_0004_0000, '0);
		send_req(fptm_pkg::REQ_UNMAP, 36'h0_0000_0001, '0);
		send_req(fptm_pkg::REQ_MAP, '1, 40'h12_3456_789A);

		for (int ph = 0; ph < 4; ph++) begin
			if (ph > 0)
				write_base(bases[ph]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 100 == 0)
					no_gaps = ($urandom_range(0, 3) == 0);
				vp = pick_vp();
				send_req($urandom_range(0, 99) < 55 ? fptm_pkg::REQ_MAP : fptm_pkg::REQ_UNMAP,
					vp, fptm_pkg::FRAME_W'({$urandom, $urandom}));
			end
			no_gaps = 1'b0;
		end

		req_if.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("tb_four_level_page_table_mapper: PASS");
		else
			$display("tb_four_level_page_table_mapper: FAIL");
		$finish;
	end
endmodule

// ===== four_level_page_table_mapper.f =====
rtl/fptm_pkg.sv
rtl/fptm_ifs.sv
rtl/fptm_ram.sv
rtl/fptm_ctrl.sv
rtl/four_level_page_table_mapper.sv
bench/fptm_checker.sv
bench/tb_four_level_page_table_mapper.sv
